// ===== hw/rtl/lpd_pkg.sv =====
package lpd_pkg;

    // Number format and degree limit
    localparam int FRAC_BITS  = 30;
    localparam int MAX_DEGREE = 64;
    localparam int DEG_W      = 7;

    // 1.0 in the fixed-point format
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    // Divider geometry: numerator is n*|u| (38 bits) scaled by 1.0
    localparam int NUM_W = 38 + FRAC_BITS;
    localparam int DEN_W = FRAC_BITS + 1;
    localparam int QUO_W = 47;

    // Divider result handed back to the sequencer
    typedef struct packed {
        logic             done;
        logic             sat;
        logic [QUO_W-1:0] quo;
    } t_div_res;

    // Round a fixed-point product magnitude to nearest and apply the sign
    function automatic logic signed [31:0] mulq_round(input logic [64:0] prod,
                                                       input logic neg);
        logic [64:0] s;
        logic [31:0] m;
        s = prod + (65'd1 << (FRAC_BITS - 1));
        m = s[FRAC_BITS+31:FRAC_BITS];
        return neg ? -$signed(m) : $signed(m);
    endfunction

endpackage

// ===== hw/rtl/lpd_mul.sv =====
module lpd_mul
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic [32:0] i_a,
    input  logic [31:0] i_b,
    output logic [64:0] o_prod
);

    logic [64:0] r_prod;

    // Register the shared product; the result appears in the cycle after issue
    always_ff @(posedge i_clk) begin
        r_prod <= 65'(i_a) * 65'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== hw/rtl/lpd_div.sv =====
module lpd_div
    import lpd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_sat;
    logic             r_done;

    logic [DEN_W:0]   n_rem2;
    logic             n_bit;

    // Shift in one numerator bit and try a subtract
    always_comb begin
        n_rem2 = {r_rem, r_num[NUM_W-1]};
        n_bit  = (n_rem2 >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_sat  <= 1'b0;
            end else if (r_busy) begin
                r_num <= r_num << 1;
                r_rem <= n_bit ? DEN_W'(n_rem2 - {1'b0, r_den}) : DEN_W'(n_rem2);
                // a bit pushed past the top marks overflow of the result field
                r_sat <= r_sat | r_quo[QUO_W-1];
                r_quo <= {r_quo[QUO_W-2:0], n_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_sat;
    assign o_res.quo  = r_quo;

endmodule

// ===== hw/rtl/legendre_poly_and_derivative.sv =====
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tdata: x_value[31:0], degree[38:32], zero fill [39]
// m_axis    out  tdata: poly_value[31:0], deriv_value[79:32]; tuser: deriv_saturated
//
// One request at a time. Degree 0 and degree 1 are answered the cycle after acceptance.
// Otherwise each recurrence step walks states XP, T, Q, C and U on the shared multiplier (x*P,
// reciprocal divide by i, correction), once for each i from 2 to n. At x = +-1.0 state F closes
// it out with a closed-form derivative. Elsewhere the final products and the divider start follow,
// then the bit-serial derivative divider produces the derivative.
// Synchronous active-low reset returns the sequencer to idle and drops the result.
// A held result stalls the block; the next request is taken after it is delivered.
module legendre_poly_and_derivative
    import lpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // x_value[31:0], degree[38:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // poly_value[31:0], deriv_value[79:32]
    output logic        o_m_axis_tuser    // deriv_saturated
);

    typedef enum logic [3:0] {
        S_IDLE, S_XP, S_T, S_Q, S_C, S_U, S_F, S_F1, S_F2, S_F3, S_DIV, S_DONE
    } t_state;

    t_state r_state;

    logic signed [31:0] r_x;
    logic [DEG_W-1:0]   r_n;
    logic [DEG_W-1:0]   r_i;
    logic signed [31:0] r_p;
    logic signed [31:0] r_pp;
    logic signed [31:0] r_xp;
    logic signed [32:0] r_t;
    logic [32:0]        r_m;
    logic [31:0]        r_q0;
    logic signed [32:0] r_u;
    logic [DEN_W-1:0]   r_den;
    logic               r_dneg;
    logic [31:0]        r_poly;
    logic [47:0]        r_deriv;
    logic               r_sat;

    logic [32:0]        w_a;
    logic [31:0]        w_b;
    logic [64:0]        w_prod;
    logic               w_div_start;
    logic [NUM_W-1:0]   w_div_num;
    t_div_res           w_div;
    logic [31:0]        w_recip [0:MAX_DEGREE];

    // Reciprocal table floor(2^32 / i), worked out at elaboration
    assign w_recip[0] = '0;
    assign w_recip[1] = '0;
    for (genvar g = 2; g <= MAX_DEGREE; g++) begin : g_recip
        localparam logic [63:0] RECIP = 64'h1_0000_0000 / 64'(g);
        assign w_recip[g] = RECIP[31:0];
    end

    // Input unpack with clamping
    logic signed [31:0] w_xin;
    logic [DEG_W-1:0]   w_nin;
    logic signed [31:0] w_xc;
    logic [DEG_W-1:0]   w_nc;
    assign w_xin = $signed(i_s_axis_tdata[31:0]);
    assign w_nin = i_s_axis_tdata[38:32];
    assign w_xc  = (w_xin > ONE) ? ONE : ((w_xin < -ONE) ? -ONE : w_xin);
    assign w_nc  = (w_nin > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : w_nin;

    // Magnitudes for the multiplier
    logic [31:0] w_xmag, w_pmag;
    logic [32:0] w_tmag, w_umag;
    assign w_xmag = r_x[31] ? 32'(-r_x) : 32'(r_x);
    assign w_pmag = r_p[31] ? 32'(-r_p) : 32'(r_p);
    assign w_tmag = r_t[32] ? 33'(-r_t) : 33'(r_t);
    assign w_umag = r_u[32] ? 33'(-r_u) : 33'(r_u);

    // Select shared multiplier operands for the current step
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_XP, S_F: begin
                w_a = {1'b0, w_xmag};
                w_b = w_pmag;
            end
            S_Q: begin
                w_a = w_tmag + 33'(r_i >> 1);
                w_b = w_recip[r_i];
            end
            S_C: begin
                // quotient estimate straight off the multiplier
                w_a = {1'b0, w_prod[63:32]};
                w_b = 32'(r_i);
            end
            S_F1: begin
                w_a = {1'b0, w_xmag};
                w_b = w_xmag;
            end
            S_F2: begin
                w_a = w_umag;
                w_b = 32'(r_n);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    lpd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    assign w_div_start = (r_state == S_F3);
    assign w_div_num   = {w_prod[37:0], {FRAC_BITS{1'b0}}};

    lpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_den),
        .o_res   (w_div)
    );

    // Step arithmetic around the multiplier result
    logic signed [31:0] w_round_xp;
    logic [32:0]        w_rem;
    logic [32:0]        w_tq_mag;
    logic signed [34:0] w_sum;
    logic signed [31:0] w_pnew;
    logic signed [31:0] w_xx;
    logic signed [32:0] w_den_s;
    logic [11:0]        w_tri;
    logic [47:0]        w_dmag;

    assign w_round_xp = mulq_round(w_prod, r_x[31] ^ r_p[31]);
    assign w_rem      = r_m - w_prod[32:0];
    assign w_tq_mag   = {1'b0, r_q0} + 33'(w_rem >= 33'(r_i));
    assign w_sum      = 35'(r_xp) + 35'(r_t)
                        - (r_t[32] ? -$signed({2'b00, w_tq_mag}) : $signed({2'b00, w_tq_mag}));
    assign w_pnew     = (w_sum > 35'(ONE)) ? ONE : ((w_sum < -35'(ONE)) ? -ONE : 32'(w_sum));
    assign w_xx       = mulq_round(w_prod, 1'b0);
    assign w_den_s    = 33'(ONE) - 33'(w_xx);
    assign w_tri      = 12'((14'(r_n) * 14'(r_n + 1'b1)) >> 1);
    assign w_dmag     = w_div.sat ? 48'h7FFF_FFFF_FFFF : {1'b0, w_div.quo};

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x    <= w_xc;
                        r_n    <= w_nc;
                        r_i    <= DEG_W'(2);
                        r_pp   <= ONE;
                        r_p    <= w_xc;
                        r_sat  <= 1'b0;
                        if (w_nc == '0) begin
                            r_poly  <= ONE;
                            r_deriv <= '0;
                            r_state <= S_DONE;
                        end else if (w_nc == DEG_W'(1)) begin
                            r_poly  <= w_xc;
                            r_deriv <= 48'(ONE);
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_XP;
                        end
                    end
                end
                S_XP: r_state <= S_T;
                S_T: begin
                    r_xp    <= w_round_xp;
                    r_t     <= 33'(w_round_xp) - 33'(r_pp);
                    r_state <= S_Q;
                end
                S_Q: begin
                    r_m     <= w_a;
                    r_state <= S_C;
                end
                S_C: begin
                    r_q0    <= w_prod[63:32];
                    r_state <= S_U;
                end
                S_U: begin
                    r_pp <= r_p;
                    r_p  <= w_pnew;
                    r_i  <= r_i + 1'b1;
                    r_state <= (r_i == r_n) ? S_F : S_XP;
                end
                S_F: begin
                    r_poly <= r_p;
                    if (r_x == ONE || r_x == -ONE) begin
                        r_deriv <= (r_x[31] && !r_n[0])
                                   ? -(48'(w_tri) << FRAC_BITS) : (48'(w_tri) << FRAC_BITS);
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F1;
                    end
                end
                S_F1: begin
                    r_u     <= 33'(w_round_xp) - 33'(r_pp);
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_den   <= (w_den_s < 33'sd1) ? DEN_W'(1) : DEN_W'(w_den_s);
                    r_dneg  <= (r_u > 33'sd0);
                    r_state <= S_F3;
                end
                S_F3: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div.done) begin
                        r_deriv <= r_dneg ? -w_dmag : w_dmag;
                        r_sat   <= w_div.sat;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_DONE);
    assign o_m_axis_tdata  = {r_deriv, r_poly};
    assign o_m_axis_tuser  = r_sat;

    // The recurrence index never runs past the degree
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XP || r_state == S_U) |-> (r_i >= DEG_W'(2) && r_i <= r_n))
        else $error("recurrence index out of range");

    // The divider finishes only while the sequencer waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider done outside wait state");

    // Intake and result never open together
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("request accepted while result pending");

    // Divider denominator is never zero when started
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F3) |-> (r_den != '0))
        else $error("zero denominator");

endmodule

// ===== sim/tb_legendre_poly_and_derivative.sv =====
`timescale 1ns / 100ps

module tb_legendre_poly_and_derivative;
    import lpd_pkg::*;

    localparam longint ONE_Q     = longint'(1) <<< FRAC_BITS;
    localparam longint DERIV_LIM = 64'h7FFF_FFFF_FFFF;

    typedef struct {
        logic signed [31:0] poly;
        logic signed [47:0] deriv;
        logic               sat;
    } t_legendre_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;   // x_value[31:0], degree[38:32], zero fill [39]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [79:0] o_m_axis_tdata;   // poly_value[31:0], deriv_value[79:32]
    logic        o_m_axis_tuser;   // deriv_saturated

    t_legendre_res legendre_expected[$];
    int          n_errors;
    int          n_results;
    int          n_sat;
    bit          idle_on;

    legendre_poly_and_derivative i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Fixed-point product, rounded to nearest with ties away from zero
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] pr;
        longint       r;
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        pr = ma * mb + (128'd1 << (FRAC_BITS - 1));
        r  = longint'(pr >> FRAC_BITS);
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint clamp_one(input longint v);
        return (v < -ONE_Q) ? -ONE_Q : ((v > ONE_Q) ? ONE_Q : v);
    endfunction

    // Evaluate P_n(x) and P_n'(x) through the three-term recurrence
    function automatic t_legendre_res legendre_eval(input logic [31:0] x_raw,
                                                    input logic [6:0] deg);
        t_legendre_res res;
        longint        x, p, pp, xp, t, tq, u, den;
        longint        n;
        logic [127:0]  num, quo;
        logic [63:0]   dmag;
        bit            dneg;
        x    = clamp_one(longint'($signed(x_raw)));
        n    = (deg > MAX_DEGREE) ? MAX_DEGREE : deg;
        dmag = 0;
        dneg = 0;
        res.sat = 1'b0;
        if (n == 0) begin
            p = ONE_Q;
        end else if (n == 1) begin
            p    = x;
            dmag = 64'(ONE_Q);
        end else begin
            pp = ONE_Q;
            p  = x;
            for (longint i = 2; i <= n; i++) begin
                xp = fx_mul(x, p);
                t  = xp - pp;
                tq = (((t < 0) ? -t : t) + i / 2) / i;
                if (t < 0)
                    tq = -tq;
                pp = p;
                p  = clamp_one(xp + t - tq);
            end
            if (x == ONE_Q || x == -ONE_Q) begin
                // closed-form limit at the interval ends
                dmag = 64'((n * (n + 1) / 2) <<< FRAC_BITS);
                dneg = (x < 0) && n[0] == 1'b0;
            end else begin
                u   = fx_mul(x, p) - pp;
                den = ONE_Q - fx_mul(x, x);
                if (den < 1)
                    den = 1;
                num = 128'((u < 0) ? -u : u) * 128'(n);
                quo = (num << FRAC_BITS) / 128'(den);
                if (quo > 128'(DERIV_LIM)) begin
                    res.sat = 1'b1;
                    dmag    = 64'(DERIV_LIM);
                end else begin
                    dmag = quo[63:0];
                end
                dneg = u > 0;
            end
        end
        res.poly  = p[31:0];
        res.deriv = dneg ? -dmag[47:0] : dmag[47:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        n_errors++;
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // Send one request, with an optional random gap before it
    task automatic send_request(input logic [31:0] x_raw, input logic [6:0] deg);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {1'b0, deg, x_raw};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        legendre_expected.push_back(legendre_eval(x_raw, deg));
        @(negedge i_clk);
    endtask

    task automatic wait_results_drained();
        i_s_axis_tvalid = 1'b0;
        while (legendre_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Random stalls on the result side
    initial begin
        i_m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge i_clk);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // Compare each delivered result against the oldest prediction
    always @(posedge i_clk) begin
        t_legendre_res want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (legendre_expected.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata[31:0], 0);
            end else begin
                want = legendre_expected.pop_front();
                n_results++;
                if (o_m_axis_tuser)
                    n_sat++;
                if (o_m_axis_tdata[31:0] !== want.poly)
                    report_mismatch("poly_value", o_m_axis_tdata[31:0], want.poly);
                if (o_m_axis_tdata[79:32] !== want.deriv)
                    report_mismatch("deriv_value", o_m_axis_tdata[79:32], want.deriv);
                if (o_m_axis_tuser !== want.sat)
                    report_mismatch("deriv_saturated", o_m_axis_tuser, want.sat);
            end
        end
    end

    function automatic logic [31:0] rand_x();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return ($urandom_range(0, 1) ? ONE_Q : -ONE_Q) + $urandom_range(0, 8) - 4;
            default: return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
    endfunction

    function automatic logic [6:0] rand_deg();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 127);
            1, 2:    return $urandom_range(40, 64);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    // Field extremes, low degrees, interval ends and clamped inputs
    task automatic test_directed();
        send_request(32'h0, 7'd0);
        send_request(32'h4000_0000, 7'd0);
        send_request(32'h2000_0000, 7'd1);
        send_request(32'hC000_0000, 7'd1);
        send_request(32'h4000_0000, 7'd64);
        send_request(32'hC000_0000, 7'd64);
        send_request(32'hC000_0000, 7'd5);
        send_request(32'hC000_0000, 7'd2);
        send_request(32'h7FFF_FFFF, 7'd7);
        send_request(32'h8000_0000, 7'd8);
        send_request(32'h3FFF_FFFF, 7'd64);
        send_request(32'hC000_0001, 7'd63);
        send_request(32'h3FFF_FFF0, 7'd30);
        send_request(32'h0, 7'd127);
        send_request(32'h1234_5678, 7'd100);
        send_request(32'h0000_0001, 7'd2);
        send_request(32'hFFFF_FFFF, 7'd3);
        send_request(32'h2000_0000, 7'd10);
        send_request(32'hE000_0000, 7'd11);
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
            send_request(rand_x(), rand_deg());
    endtask

    // Send a random run, pause the sender until the block has answered everything, then send another
    task automatic test_drained_pause();
        test_random(20);
        wait_results_drained();
        test_random(20);
    endtask

    initial begin
        int guard;
        n_errors        = 0;
        n_results       = 0;
        n_sat           = 0;
        idle_on         = 1'b1;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(1200);
        test_drained_pause();
        idle_on = 1'b0;
        test_random(300);

        i_s_axis_tvalid = 1'b0;
        guard = 0;
        while (legendre_expected.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (legendre_expected.size() != 0)
            report_mismatch("results still missing", legendre_expected.size(), 0);
        $display("Covered %0d results (%0d saturated derivatives): directed extremes,",
                 n_results, n_sat);
        $display("random points and degrees with stalls, a drained pause and a no-gap run.");
        if (n_errors == 0) begin
            $display("tb_legendre_poly_and_derivative: done, clean");
        end else begin
            $display("tb_legendre_poly_and_derivative: done, errors");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("tb_legendre_poly_and_derivative: done, errors");
        $finish;
    end

endmodule
